// ===== rtl/htbd_pkg.sv =====
// Package for the Huffman tree bit decoder: word types, node record and codes.
// Used by the walker and the top level; depends on nothing.
package htbd_pkg;

    localparam int NODE_COUNT_DEF = 512;
    localparam int CHILD_W        = 9;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 32;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [CHILD_W-1:0] node_index;
        logic               node_is_leaf;
        logic [SYM_W-1:0]   node_symbol;
        logic [CHILD_W-1:0] left_child;
        logic [CHILD_W-1:0] right_child;
        logic [7:0]         code_byte;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             finished;
    } t_out_word;

    typedef struct packed {
        logic               leaf;
        logic [SYM_W-1:0]   symbol;
        logic [CHILD_W-1:0] left_child;
        logic [CHILD_W-1:0] right_child;
    } t_node;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

endpackage

// ===== rtl/htbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds while no read is enabled. Depends on nothing.
module htbd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/htbd_walker.sv =====
// Tree walker: loads nodes, walks code bits one per cycle through the node RAM while the output
// is not stalled, and delivers symbols through a hold stage and an output register. Uses htbd_pkg.
module htbd_walker import htbd_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  t_in_word                      i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output t_out_word                     o_out_word,
    input  logic [CNT_W-1:0]              i_total,
    output logic                          o_ram_we,
    output logic [$clog2(NODE_COUNT)-1:0] o_ram_waddr,
    output t_node                         o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(NODE_COUNT)-1:0] o_ram_raddr,
    input  t_node                         i_ram_rdata
);

    localparam int AW = $clog2(NODE_COUNT);

    t_state           r_state, n_state;
    logic [7:0]       r_byte, n_byte;
    logic [3:0]       r_left, n_left;
    logic             r_land, n_land;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_cur, n_cur;
    logic [CNT_W-1:0] r_count, n_count;
    t_node            r_root, n_root;
    logic             r_hold_v, n_hold_v;
    logic [SYM_W-1:0] r_hold_sym, n_hold_sym;
    logic             r_hold_fin, n_hold_fin;
    logic             r_out_v, n_out_v;
    t_out_word        r_out, n_out;

    logic             out_free;
    logic             out_load;
    logic             leaf_hit;
    logic [CNT_W-1:0] cnt_inc;
    logic             fin;
    logic             step_ok;
    t_node            cur_rec;
    logic [AW-1:0]    cur_idx;
    logic             bit_sel;
    logic [CHILD_W-1:0] child;
    logic [AW-1:0]    nxt;
    logic             move;
    logic             load_ok;
    t_node            load_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_land   <= 1'b0;
            r_left   <= '0;
            r_cur    <= '0;
            r_count  <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_land   <= n_land;
            r_left   <= n_left;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_addr     <= n_addr;
        r_root     <= n_root;
        r_hold_sym <= n_hold_sym;
        r_hold_fin <= n_hold_fin;
        r_out      <= n_out;
    end

    assign out_free  = !r_out_v || !i_out_stall;
    assign leaf_hit  = (r_state == S_WALK) && r_land && i_ram_rdata.leaf;
    assign cnt_inc   = r_count + CNT_W'(1);
    assign fin       = (cnt_inc == i_total);
    assign step_ok   = !(leaf_hit && r_hold_v && !out_free);
    assign cur_rec   = leaf_hit ? r_root : i_ram_rdata;
    assign cur_idx   = leaf_hit ? '0 : r_addr;
    assign bit_sel   = r_byte[3'(r_left - 4'd1)];
    assign child     = bit_sel ? cur_rec.left_child : cur_rec.right_child;
    assign nxt       = (32'(child) < NODE_COUNT) ? AW'(child) : '0;
    assign move      = (r_left != 4'd0) && !(leaf_hit && fin);
    assign load_ok   = (32'(i_in_word.node_index) < NODE_COUNT);
    assign load_node = '{leaf:        i_in_word.node_is_leaf,
                         symbol:      i_in_word.node_symbol,
                         left_child:  i_in_word.left_child,
                         right_child: i_in_word.right_child};

    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_left     = r_left;
        n_land     = r_land;
        n_addr     = r_addr;
        n_cur      = r_cur;
        n_count    = r_count;
        n_root     = r_root;
        n_hold_v   = r_hold_v;
        n_hold_sym = r_hold_sym;
        n_hold_fin = r_hold_fin;
        n_out      = r_out;
        out_load   = 1'b0;
        o_ram_we   = 1'b0;
        o_ram_re   = 1'b0;
        o_ram_raddr = nxt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.kind == KIND_LOAD) begin
                        if (load_ok) begin
                            o_ram_we = 1'b1;
                            if (AW'(i_in_word.node_index) == '0) begin
                                n_root = load_node;
                            end
                        end
                    end else if (r_count < i_total) begin
                        n_byte      = i_in_word.code_byte;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_cur;
                        n_addr      = r_cur;
                        n_land      = 1'b0;
                        n_left      = BYTE_BITS;
                        n_state     = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (step_ok) begin
                    if (leaf_hit) begin
                        n_count = cnt_inc;
                        if (r_hold_v) begin
                            out_load = 1'b1;
                            n_out    = '{symbol: r_hold_sym, last: 1'b0,
                                         finished: r_hold_fin};
                        end
                        n_hold_v   = 1'b1;
                        n_hold_sym = i_ram_rdata.symbol;
                        n_hold_fin = fin;
                    end
                    if (move) begin
                        o_ram_re = 1'b1;
                        n_addr   = nxt;
                        n_land   = 1'b1;
                        n_left   = r_left - 4'd1;
                    end else begin
                        n_cur   = cur_idx;
                        n_land  = 1'b0;
                        n_state = (r_hold_v || leaf_hit) ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = '{symbol: r_hold_sym, last: 1'b1, finished: r_hold_fin};
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_v = out_load ? 1'b1 : (r_out_v && i_out_stall);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;
    assign o_ram_waddr = AW'(i_in_word.node_index);
    assign o_ram_wdata = load_node;

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v)
        else $error("symbol left in hold stage while idle");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= BYTE_BITS)
        else $error("bit counter beyond one byte");

    a_read_on_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_ram_re) |-> (i_in_valid && i_in_word.kind == KIND_DECODE))
        else $error("node read issued while idle without a decode word");

    a_not_last_keeps_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !n_out.last) |=> r_hold_v)
        else $error("non-final symbol sent without a following symbol held");

endmodule

// ===== rtl/huffman_tree_bit_decoder_top.sv =====
// A code byte walks one node RAM read per bit, fewer if the symbol total stops it, and the last
// held symbol is flushed after the walk. No new input word is taken until the walker is idle again.
// Reset (synchronous, active low) clears the symbol total, count and walk position to the root.
// The node table is not cleared and must be loaded before it is read.
// Top level: symbol total register, tree walker and node table RAM.
// Depends on htbd_pkg, htbd_ram and htbd_walker.
module huffman_tree_bit_decoder_top import htbd_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(NODE_COUNT);

    logic [CNT_W-1:0] r_total;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_node            ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    t_node            ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
        end
    end

    htbd_walker #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_total     (r_total),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    htbd_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
